/* hdl/mfx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfx_pkg: memory card frame transfer shared types
// Holds the beat payload structs, the command codes and the status codes.
// ----------------------------------------------------------------------------
package mfx_pkg;

  localparam logic [1:0] CMD_START_READ  = 2'd0;
  localparam logic [1:0] CMD_START_WRITE = 2'd1;
  localparam logic [1:0] CMD_EXCHANGE    = 2'd2;

  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_ACK    = 3'd3;
  localparam logic [2:0] ST_NO_FLAG    = 3'd4;
  localparam logic [2:0] ST_ADDR_ERR   = 3'd5;
  localparam logic [2:0] ST_SUM_ERR    = 3'd6;
  localparam logic [2:0] ST_BAD_END    = 3'd7;

  localparam logic [7:0] TAP_BASE     = 8'h80;
  localparam logic [7:0] CMD_READ     = 8'h52;
  localparam logic [7:0] CMD_WRITE    = 8'h57;
  localparam logic [7:0] ID_FIRST     = 8'h5a;
  localparam logic [7:0] ID_SECOND    = 8'h5d;
  localparam logic [7:0] ACK_MARK     = 8'h5c;
  localparam logic [7:0] START_FLAG   = 8'h5d;
  localparam logic [7:0] END_FLAG     = 8'h47;
  localparam logic [9:0] POLLS_RESET  = 10'd255;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] frame_number;
    logic [6:0] tap_select;
    logic [7:0] rx_byte;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       await_ack;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] checksum;
  } out_t;

endpackage

/* hdl/mfx_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfx_seq: frame transfer phase sequencer
// Holds the transaction state and computes the result for one input beat.
// ----------------------------------------------------------------------------
module mfx_seq
  import mfx_pkg::*;
#(
  parameter int FRAME_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_t        item,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data,
  output out_t       res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_HDR0, PH_HDR1, PH_ID1, PH_ID2, PH_ADR_HI, PH_ADR_LO,
    PH_R_ACK, PH_R_POLL, PH_R_EHI, PH_R_ELO, PH_R_DATA, PH_R_XOR, PH_R_END,
    PH_W_DATA, PH_W_XOR, PH_W_EMK1, PH_W_EMK2, PH_W_EFL
  } phase_t;

  localparam logic [9:0] FrameLen = 10'(FRAME_BYTES);

  phase_t     phase, phase_next;
  logic       is_write, is_write_next;
  logic [9:0] byte_count, byte_count_next;
  logic [9:0] frame_reg, frame_reg_next;
  logic [7:0] xor_acc, xor_acc_next;
  logic [9:0] max_flag_polls;

  logic [7:0] addr_hi, addr_lo, rx, wb;
  logic [9:0] count_inc;

  assign addr_hi   = {6'd0, frame_reg[9:8]};
  assign addr_lo   = frame_reg[7:0];
  assign rx        = item.rx_byte;
  assign wb        = item.write_byte;
  assign count_inc = byte_count + 10'd1;

  always_comb begin
    res             = '0;
    phase_next      = phase;
    is_write_next   = is_write;
    byte_count_next = byte_count;
    frame_reg_next  = frame_reg;
    xor_acc_next    = xor_acc;
    if (item.cmd == CMD_START_READ || item.cmd == CMD_START_WRITE) begin
      is_write_next   = item.cmd[0];
      frame_reg_next  = item.frame_number;
      byte_count_next = '0;
      xor_acc_next    = '0;
      res.tx_byte     = TAP_BASE | {1'b0, item.tap_select};
      res.tx_valid    = 1'b1;
      res.await_ack   = item.cmd[0];
      phase_next      = PH_HDR0;
    end else if (item.cmd == CMD_EXCHANGE) begin
      // finish paths below set done and fall back to idle
      unique case (phase)
        PH_HDR0: begin
          res.tx_byte   = is_write ? CMD_WRITE : CMD_READ;
          res.tx_valid  = 1'b1;
          res.await_ack = is_write;
          phase_next    = PH_HDR1;
        end
        PH_HDR1: begin
          res.tx_valid  = 1'b1;
          res.await_ack = is_write;
          phase_next    = PH_ID1;
        end
        PH_ID1: begin
          if (rx != ID_FIRST) begin
            res.done_res = 1'b1;
            res.status   = ST_BAD_HEADER;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_valid  = 1'b1;
            res.await_ack = is_write;
            phase_next    = PH_ID2;
          end
        end
        PH_ID2: begin
          if (rx != ID_SECOND) begin
            res.done_res = 1'b1;
            res.status   = ST_BAD_HEADER;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_byte  = addr_hi;
            res.tx_valid = 1'b1;
            phase_next   = PH_ADR_HI;
          end
        end
        PH_ADR_HI: begin
          res.tx_byte  = addr_lo;
          res.tx_valid = 1'b1;
          phase_next   = PH_ADR_LO;
        end
        PH_ADR_LO: begin
          res.tx_valid = 1'b1;
          if (is_write) begin
            // first payload byte is sent unconditionally: frame length must be at least one
            xor_acc_next    = addr_hi ^ addr_lo ^ wb;
            byte_count_next = 10'd1;
            res.tx_byte     = wb;
            phase_next      = PH_W_DATA;
          end else begin
            res.await_ack = 1'b1;
            phase_next    = PH_R_ACK;
          end
        end
        PH_R_ACK: begin
          if (rx != ACK_MARK) begin
            res.done_res = 1'b1;
            res.status   = ST_BAD_ACK;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            byte_count_next = '0;
            res.tx_valid    = 1'b1;
            phase_next      = PH_R_POLL;
          end
        end
        PH_R_POLL: begin
          if (byte_count >= max_flag_polls) begin
            res.done_res = 1'b1;
            res.status   = ST_NO_FLAG;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            byte_count_next = count_inc;
            res.tx_valid    = 1'b1;
            phase_next      = (rx == START_FLAG) ? PH_R_EHI : PH_R_POLL;
          end
        end
        PH_R_EHI: begin
          if (rx != addr_hi) begin
            res.done_res = 1'b1;
            res.status   = ST_ADDR_ERR;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_valid = 1'b1;
            phase_next   = PH_R_ELO;
          end
        end
        PH_R_ELO: begin
          if (rx != addr_lo) begin
            res.done_res = 1'b1;
            res.status   = ST_ADDR_ERR;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            byte_count_next = '0;
            xor_acc_next    = addr_hi ^ addr_lo;
            res.tx_valid    = 1'b1;
            phase_next      = PH_R_DATA;
          end
        end
        PH_R_DATA: begin
          res.read_data   = rx;
          res.read_valid  = 1'b1;
          res.tx_valid    = 1'b1;
          xor_acc_next    = xor_acc ^ rx;
          byte_count_next = count_inc;
          if (count_inc >= FrameLen) begin
            res.read_last = 1'b1;
            phase_next    = PH_R_XOR;
          end else begin
            phase_next    = PH_R_DATA;
          end
        end
        PH_R_XOR: begin
          if (rx != xor_acc) begin
            res.done_res = 1'b1;
            res.status   = ST_SUM_ERR;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_valid = 1'b1;
            phase_next   = PH_R_END;
          end
        end
        PH_R_END, PH_W_EFL: begin
          res.done_res = 1'b1;
          res.status   = (rx == END_FLAG) ? ST_OK : ST_BAD_END;
          res.checksum = xor_acc;
          phase_next   = PH_IDLE;
        end
        PH_W_DATA: begin
          res.tx_valid = 1'b1;
          if (byte_count < FrameLen) begin
            xor_acc_next    = xor_acc ^ wb;
            byte_count_next = count_inc;
            res.tx_byte     = wb;
            phase_next      = PH_W_DATA;
          end else begin
            res.tx_byte = xor_acc;
            phase_next  = PH_W_XOR;
          end
        end
        PH_W_XOR: begin
          res.tx_valid  = 1'b1;
          res.await_ack = 1'b1;
          phase_next    = PH_W_EMK1;
        end
        PH_W_EMK1: begin
          if (rx != ACK_MARK) begin
            res.done_res = 1'b1;
            res.status   = ST_BAD_ACK;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_valid  = 1'b1;
            res.await_ack = 1'b1;
            phase_next    = PH_W_EMK2;
          end
        end
        PH_W_EMK2: begin
          if (rx != START_FLAG) begin
            res.done_res = 1'b1;
            res.status   = ST_BAD_ACK;
            res.checksum = xor_acc;
            phase_next   = PH_IDLE;
          end else begin
            res.tx_valid  = 1'b1;
            res.await_ack = 1'b1;
            phase_next    = PH_W_EFL;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_write       <= 1'b0;
      byte_count     <= '0;
      frame_reg      <= '0;
      xor_acc        <= '0;
      max_flag_polls <= POLLS_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_flag_polls <= cfg_wr_data;
      end
      if (advance) begin
        phase      <= phase_next;
        is_write   <= is_write_next;
        byte_count <= byte_count_next;
        frame_reg  <= frame_reg_next;
        xor_acc    <= xor_acc_next;
      end
    end
  end

endmodule

/* hdl/memcard_frame_transfer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memcard_frame_transfer_core: memory card frame read/write byte sequencer
// Master-side byte sequencer for one frame read or write with a memory card.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): a start beat carries the
//   operation, frame number and tap slot; each later exchange beat reports
//   the byte the card returned and, for writes, the next payload byte.
//   Output channel (out_valid / out_stall / out_data): exactly one result
//   beat per input beat, giving the next byte to send, the acknowledge-wait
//   flag, received data bytes on reads, and done/status/checksum at the end.
//   Config: cfg_wr_en / cfg_wr_data set the poll limit for the start flag;
//   write it only while no transaction is in flight.
// Pipeline and throughput:
//   The input register loads at the accepting edge and the result register
//   loads when the beat advances, which waits while out_stall holds a
//   pending result. One beat per cycle is sustained while out_stall is low;
//   the sequencer computes each result combinationally between the two
//   registers.
// Reset (rst, synchronous): phase idle, counters and XOR cleared, poll limit
//   back to 255, both pipeline registers empty.
// Stall: when out_stall holds a pending result, the input register keeps
//   its beat and in_stall rises until the result register can take it.
// ----------------------------------------------------------------------------
module memcard_frame_transfer_core
  import mfx_pkg::*;
#(
  parameter int FRAME_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [9:0] cfg_wr_data
);

  logic in_reg_valid;
  in_t  in_reg;
  logic advance;
  out_t res;

  // Move the held beat forward whenever the result register is free or drains.
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  mfx_seq #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_reg),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  // Valid bits for both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
    if (advance) begin
      out_data <= res;
    end
  end

endmodule
